// ===== rtl/hjg_pkg.sv =====
package hjg_pkg;

    localparam int JIT_W   = 16;
    localparam int PROJ_W  = 26;
    localparam int IDX_W   = 7;
    localparam int QL_W    = 3;
    localparam int DIM_W   = 15;
    localparam int CIDX_W  = 2;
    localparam int R3_W    = 8;

    localparam logic [CIDX_W-1:0] CFG_QUALITY = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT  = 2'd2;

    localparam logic [QL_W-1:0]  QUALITY_RST = 3'd2;
    localparam logic [DIM_W-1:0] WIDTH_RST   = 15'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RST  = 15'd1080;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIG,
        S_FRAC,
        S_PROJ,
        S_LOAD
    } t_state;

    function automatic logic [IDX_W-1:0] count_of(input logic [QL_W-1:0] q);
        logic [IDX_W-1:0] c;
        unique case (q)
            3'd0:    c = 7'd96;
            3'd1:    c = 7'd80;
            3'd2:    c = 7'd64;
            3'd3:    c = 7'd48;
            3'd4:    c = 7'd48;
            3'd5:    c = 7'd48;
            default: c = 7'd32;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/hjg_req_if.sv =====
interface hjg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// ===== rtl/hjg_smp_if.sv =====
interface hjg_smp_if
    import hjg_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [JIT_W-1:0]  jit_x;
    logic signed [JIT_W-1:0]  jit_y;
    logic signed [PROJ_W-1:0] proj_x;
    logic signed [PROJ_W-1:0] proj_y;

    modport source (output valid, output jit_x, output jit_y,
                    output proj_x, output proj_y, input ready);
    modport sink   (input valid, input jit_x, input jit_y,
                    input proj_x, input proj_y, output ready);
endinterface

// ===== rtl/hjg_rinv3.sv =====
module hjg_rinv3
    import hjg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IDX_W-1:0] i_n,
    output logic             o_done,
    output logic [R3_W-1:0]  o_num,
    output logic [R3_W-1:0]  o_den
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [IDX_W-1:0] r_n, n_n;
    logic [R3_W-1:0]  r_num, n_num;
    logic [R3_W-1:0]  r_den, n_den;

    logic [15:0]      prod;
    logic [IDX_W-1:0] quo;
    logic [IDX_W-1:0] rem_full;
    logic [1:0]       dig;

    // Multiplying by 171/512 gives n/3 exactly for every 7-bit n.
    always_comb begin
        prod     = 16'(r_n) * 16'd171;
        quo      = prod[15:9];
        rem_full = r_n - IDX_W'({quo, 1'b0}) - quo;
        dig      = rem_full[1:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_n    = r_n;
        n_num  = r_num;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_n    = i_n;
            n_num  = '0;
            n_den  = R3_W'(1);
        end else if (r_busy) begin
            n_n   = quo;
            n_num = R3_W'({1'b0, r_num, 1'b0} + {2'b00, r_num} + {8'd0, dig});
            n_den = R3_W'({1'b0, r_den, 1'b0} + {2'b00, r_den});
            if (quo == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_n   <= n_n;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_num  = r_num;
    assign o_den  = r_den;

endmodule

// ===== rtl/hjg_sdiv.sv =====
module hjg_sdiv #(
    parameter int DW = 26,
    parameter int RW = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [RW-1:0] i_rem,
    input  logic [DW-1:0] i_dvd,
    input  logic [RW-1:0] i_dvs,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [RW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [RW-1:0] r_dvs, n_dvs;

    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_rem  = i_rem;
            n_quo  = i_dvd;
            n_dvs  = i_dvs;
        end else if (r_busy) begin
            n_rem = ge ? diff[RW-1:0] : trial[RW-1:0];
            n_quo = {r_quo[DW-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/halton_jitter_generator.sv =====
// Channel   Dir  Fields                                  Beat taken when
// i_req     in   restart                                 valid && ready
// o_smp     out  jit_x, jit_y, proj_x, proj_y            valid && ready
// i_cfg_*   in   index, data                             i_cfg_we high
//
// A request runs from its accepting edge to a valid sample through the chain of the base-3
// digit loop (one to five digits), the bit-serial base-3 fraction divider and the 26-step
// bit-serial projection divider for y; x runs alongside. The next request is taken once the
// finished sample has been loaded into the output register.
// Synchronous active-low reset clears the index and restores register defaults.
// A new request is taken while a finished sample waits in the output register.
module halton_jitter_generator
    import hjg_pkg::*;
#(
    parameter int SAMPLE_LIMIT = 96,
    parameter int FRAC_BITS    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hjg_req_if.sink           i_req,
    hjg_smp_if.source         o_smp,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]  i_cfg_data
);

    localparam int FQ_W = FRAC_BITS + 1;

    t_state           r_state, n_state;
    logic [QL_W-1:0]  r_quality;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [IDX_W-1:0] r_idx;
    logic [FRAC_BITS-1:0] r_jx;
    logic [FRAC_BITS-1:0] r_jy;
    logic             r_xdone;
    logic             r_ydone;
    logic             r_ovalid;
    logic [JIT_W-1:0]  r_jit_x, r_jit_y;
    logic [PROJ_W-1:0] r_proj_x, r_proj_y;

    logic             accept;
    logic             load;
    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] n_num;
    logic [IDX_W-1:0] rev;
    logic [FRAC_BITS-1:0] jx_c;
    logic [FRAC_BITS-1:0] jy_c;
    logic [FRAC_BITS+1:0] fsum;
    logic [FRAC_BITS-1:0] xmag, ymag;
    logic [IDX_W-1:0] cnt_raw, cnt;
    logic [IDX_W-1:0] adv0, adv1, adv2, adv3;
    logic [DIM_W-1:0] dw, dh;

    logic             r3_done;
    logic [R3_W-1:0]  r3_num, r3_den;
    logic             fq_start, fq_done;
    logic [FQ_W-1:0]  fq_quo;
    logic             px_done, py_done;
    logic [PROJ_W-1:0] px_quo, py_quo;
    logic [PROJ_W:0]  px_rnd, py_rnd;
    logic [PROJ_W-1:0] qx, qy;

    function automatic logic [JIT_W-1:0] sat16(input logic [FRAC_BITS-1:0] v);
        logic signed [31:0] s;
        s = 32'(signed'(v));
        if (s > 32'sd32767) begin
            return 16'h7FFF;
        end else if (s < -32'sd32768) begin
            return 16'h8000;
        end
        return s[JIT_W-1:0];
    endfunction

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        cur_idx = i_req.restart ? '0 : r_idx;
        n_num   = cur_idx + IDX_W'(1);
        for (int i = 0; i < IDX_W; i++) begin
            rev[i] = n_num[IDX_W-1-i];
        end
        jx_c = {~rev[IDX_W-1], rev[IDX_W-2:0], {(FRAC_BITS-IDX_W){1'b0}}};
        xmag = jx_c[FRAC_BITS-1] ? FRAC_BITS'(-jx_c) : jx_c;

        cnt_raw = count_of(r_quality);
        cnt     = (cnt_raw > IDX_W'(SAMPLE_LIMIT)) ? IDX_W'(SAMPLE_LIMIT) : cnt_raw;
        adv0    = n_num;
        adv1    = (adv0 >= cnt) ? adv0 - cnt : adv0;
        adv2    = (adv1 >= cnt) ? adv1 - cnt : adv1;
        adv3    = (adv2 >= cnt) ? adv2 - cnt : adv2;

        fsum = (FRAC_BITS+2)'(fq_quo) + (FRAC_BITS+2)'(1);
        jy_c = {~fsum[FRAC_BITS], fsum[FRAC_BITS-1:1]};
        ymag = jy_c[FRAC_BITS-1] ? FRAC_BITS'(-jy_c) : jy_c;

        dw = (r_width == '0) ? DIM_W'(1) : r_width;
        dh = (r_height == '0) ? DIM_W'(1) : r_height;

        px_rnd = (PROJ_W+1)'(px_quo) + (PROJ_W+1)'(1);
        py_rnd = (PROJ_W+1)'(py_quo) + (PROJ_W+1)'(1);
        qx     = px_rnd[PROJ_W:1];
        qy     = py_rnd[PROJ_W:1];
    end

    assign fq_start = r3_done;

    hjg_rinv3 u_rinv3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_n     (n_num),
        .o_done  (r3_done),
        .o_num   (r3_num),
        .o_den   (r3_den)
    );

    hjg_sdiv #(.DW(FQ_W), .RW(R3_W)) u_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fq_start),
        .i_rem   (r3_num),
        .i_dvd   ('0),
        .i_dvs   (r3_den),
        .o_done  (fq_done),
        .o_quo   (fq_quo)
    );

    hjg_sdiv #(.DW(PROJ_W), .RW(DIM_W)) u_proj_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_rem   ('0),
        .i_dvd   (PROJ_W'(xmag) << (PROJ_W - FRAC_BITS)),
        .i_dvs   (dw),
        .o_done  (px_done),
        .o_quo   (px_quo)
    );

    hjg_sdiv #(.DW(PROJ_W), .RW(DIM_W)) u_proj_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fq_done),
        .i_rem   ('0),
        .i_dvd   (PROJ_W'(ymag) << (PROJ_W - FRAC_BITS)),
        .i_dvs   (dh),
        .o_done  (py_done),
        .o_quo   (py_quo)
    );

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (r3_done) begin
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                if (fq_done) begin
                    n_state = S_PROJ;
                end
            end
            S_PROJ: begin
                if (r_xdone && r_ydone) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_ovalid || o_smp.ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_quality <= QUALITY_RST;
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
            r_idx     <= '0;
            r_xdone   <= 1'b0;
            r_ydone   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_QUALITY: r_quality <= i_cfg_data[QL_W-1:0];
                    CFG_WIDTH:   r_width   <= i_cfg_data;
                    CFG_HEIGHT:  r_height  <= i_cfg_data;
                    default:     ;
                endcase
            end
            if (accept) begin
                r_idx   <= adv3;
                r_xdone <= 1'b0;
                r_ydone <= 1'b0;
            end else begin
                if (px_done) begin
                    r_xdone <= 1'b1;
                end
                if (py_done) begin
                    r_ydone <= 1'b1;
                end
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_smp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (accept) begin
            r_jx <= jx_c;
        end
        if (fq_done) begin
            r_jy <= jy_c;
        end
        if (load) begin
            r_jit_x  <= sat16(r_jx);
            r_jit_y  <= sat16(r_jy);
            r_proj_x <= r_jx[FRAC_BITS-1] ? PROJ_W'(-qx) : qx;
            r_proj_y <= r_jy[FRAC_BITS-1] ? qy : PROJ_W'(-qy);
        end
    end

    assign o_smp.valid  = r_ovalid;
    assign o_smp.jit_x  = r_jit_x;
    assign o_smp.jit_y  = r_jit_y;
    assign o_smp.proj_x = r_proj_x;
    assign o_smp.proj_y = r_proj_y;

endmodule
